/* rtl/core/lav_pkg.sv */
// Shared types, widths and helpers for the look-at view matrix core.
// No dependencies; imported by lav_norm and look_at_view_matrix_core.
package lav_pkg;

    localparam int VEC_W      = 50;  // signed vector component into a normalizer
    localparam int NRM_W      = 31;  // normalized magnitude, top bit at 30
    localparam int SQ_W       = 64;  // sum of squares and root working width
    localparam int LEN_W      = 32;  // integer root
    localparam int QUO_W      = 17;  // unit magnitude, at most 65536
    localparam int REM_W      = 50;  // divider remainder
    localparam int UNIT_W     = 18;  // signed unit component
    localparam int SIDE_W     = 192; // payload carried alongside a normalizer
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int TOTAL_LAT  = 120;

    typedef logic signed [VEC_W-1:0]  vec_comp_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic [SIDE_W-1:0]        side_t;

    // per-item control that rides through the normalizer stages
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        side_t      side;
    } carry_t;

    // index of the highest set bit of a 25-bit word
    function automatic logic [4:0] top_pos25(input logic [24:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 25; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
        return p;
    endfunction

endpackage

/* rtl/core/lav_norm.sv */
// Pipelined vector normalizer: shift to a fixed range, root, three dividers.
// Depends on lav_pkg. One item per cycle.
module lav_norm import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  vec_comp_t in_vec [3],
    input  side_t     in_side,
    output logic      out_valid,
    output unit_t     out_unit [3],
    output side_t     out_side
);

    // stage 1: magnitudes, signs, largest magnitude
    logic              s1_v_reg;
    logic [2:0][49:0]  s1_mag_reg, s1_mag_next;
    logic [49:0]       s1_max_reg, s1_max_next;
    carry_t            s1_c_reg, s1_c_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_c_next.neg[i] = in_vec[i][VEC_W-1];
            s1_mag_next[i]   = in_vec[i][VEC_W-1] ? 50'(-in_vec[i]) : 50'(in_vec[i]);
        end
        s1_max_next = s1_mag_next[0];
        if (s1_mag_next[1] > s1_max_next)
            s1_max_next = s1_mag_next[1];
        if (s1_mag_next[2] > s1_max_next)
            s1_max_next = s1_mag_next[2];
        s1_c_next.zero = (s1_max_next == '0);
        s1_c_next.side = in_side;
    end

    // stage 2: leading-one search on both halves
    logic              s2_v_reg;
    logic [2:0][49:0]  s2_mag_reg;
    logic [4:0]        s2_hpos_reg, s2_lpos_reg;
    logic              s2_hnz_reg;
    carry_t            s2_c_reg;

    // stage 3: shift so the largest magnitude lands in [2^30, 2^31)
    logic              s3_v_reg;
    logic [2:0][30:0]  s3_mag_reg, s3_mag_next;
    carry_t            s3_c_reg;
    logic [5:0]        s3_pos;
    logic [49:0]       s3_wide;

    always_comb
    begin
        s3_pos = s2_hnz_reg ? 6'(s2_hpos_reg) + 6'd25 : 6'(s2_lpos_reg);
        for (int i = 0; i < 3; i++)
        begin
            if (s3_pos >= 6'd30)
                s3_wide = s2_mag_reg[i] >> (s3_pos - 6'd30);
            else
                s3_wide = s2_mag_reg[i] << (6'd30 - s3_pos);
            s3_mag_next[i] = s3_wide[NRM_W-1:0];
        end
    end

    // stage 4: squares
    logic              s4_v_reg;
    logic [2:0][61:0]  s4_sq_reg;
    logic [2:0][30:0]  s4_mag_reg;
    carry_t            s4_c_reg;

    // root pipeline, one result bit per stage; index 0 holds the sum
    logic [SQRT_STEPS:0]     rt_v_reg;
    logic [SQ_W-1:0]         rt_s_reg   [SQRT_STEPS+1];
    logic [SQ_W-1:0]         rt_r_reg   [SQRT_STEPS+1];
    logic [2:0][NRM_W-1:0]   rt_mag_reg [SQRT_STEPS+1];
    carry_t                  rt_c_reg   [SQRT_STEPS+1];

    // divider pipeline, one quotient bit per stage
    logic [QUO_W:0]          dv_v_reg;
    logic [2:0][REM_W-1:0]   dv_rem_reg [QUO_W+1];
    logic [2:0][QUO_W-1:0]   dv_q_reg   [QUO_W+1];
    logic [LEN_W:0]          dv_den_reg [QUO_W+1];
    carry_t                  dv_c_reg   [QUO_W+1];

    logic [LEN_W-1:0]        len;
    logic [2:0][REM_W-1:0]   num_next;

    assign len = rt_r_reg[SQRT_STEPS][LEN_W-1:0];

    // numerator mag * 2^17 + len, rounding to nearest
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num_next[i] = {2'b00, rt_mag_reg[SQRT_STEPS][i], 17'b0} + REM_W'(len);
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            rt_v_reg[0] <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            s1_v_reg    <= in_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            rt_v_reg[0] <= s4_v_reg;
            dv_v_reg[0] <= rt_v_reg[SQRT_STEPS];
        end
    end

    // advance payload of the front stages
    always_ff @(posedge clk)
    begin
        s1_mag_reg  <= s1_mag_next;
        s1_max_reg  <= s1_max_next;
        s1_c_reg    <= s1_c_next;
        s2_mag_reg  <= s1_mag_reg;
        s2_hpos_reg <= top_pos25(s1_max_reg[49:25]);
        s2_lpos_reg <= top_pos25(s1_max_reg[24:0]);
        s2_hnz_reg  <= (s1_max_reg[49:25] != '0);
        s2_c_reg    <= s1_c_reg;
        s3_mag_reg  <= s3_mag_next;
        s3_c_reg    <= s2_c_reg;
        for (int i = 0; i < 3; i++)
            s4_sq_reg[i] <= s3_mag_reg[i] * s3_mag_reg[i];
        s4_mag_reg  <= s3_mag_reg;
        s4_c_reg    <= s3_c_reg;
        rt_s_reg[0]   <= SQ_W'(s4_sq_reg[0]) + SQ_W'(s4_sq_reg[1]) + SQ_W'(s4_sq_reg[2]);
        rt_r_reg[0]   <= '0;
        rt_mag_reg[0] <= s4_mag_reg;
        rt_c_reg[0]   <= s4_c_reg;
        dv_rem_reg[0] <= num_next;
        dv_q_reg[0]   <= '0;
        dv_den_reg[0] <= {len, 1'b0};
        dv_c_reg[0]   <= rt_c_reg[SQRT_STEPS];
    end

    // root stages
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] s_next, r_next;

        always_comb
        begin
            trial = rt_r_reg[k] + BIT;
            if (rt_s_reg[k] >= trial)
            begin
                s_next = rt_s_reg[k] - trial;
                r_next = (rt_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                s_next = rt_s_reg[k];
                r_next = rt_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[k+1] <= 1'b0;
            else
                rt_v_reg[k+1] <= rt_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rt_s_reg[k+1]   <= s_next;
            rt_r_reg[k+1]   <= r_next;
            rt_mag_reg[k+1] <= rt_mag_reg[k];
            rt_c_reg[k+1]   <= rt_c_reg[k];
        end
    end

    // divider stages, three lanes
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int B = QUO_W - 1 - j;
        logic [REM_W-1:0]      dsh;
        logic [2:0][REM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;

        always_comb
        begin
            dsh = REM_W'(dv_den_reg[j]) << B;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = dv_rem_reg[j][i];
                q_next[i]   = dv_q_reg[j][i];
                if (dv_rem_reg[j][i] >= dsh)
                begin
                    rem_next[i]  = dv_rem_reg[j][i] - dsh;
                    q_next[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j+1] <= rem_next;
            dv_q_reg[j+1]   <= q_next;
            dv_den_reg[j+1] <= dv_den_reg[j];
            dv_c_reg[j+1]   <= dv_c_reg[j];
        end
    end

    // output stage: apply signs, force zero vector
    logic  out_v_reg;
    unit_t out_u_reg [3];
    side_t out_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= dv_v_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_c_reg[QUO_W].zero)
                out_u_reg[i] <= '0;
            else if (dv_c_reg[QUO_W].neg[i])
                out_u_reg[i] <= -$signed({1'b0, dv_q_reg[QUO_W][i]});
            else
                out_u_reg[i] <= $signed({1'b0, dv_q_reg[QUO_W][i]});
        end
        out_s_reg <= dv_c_reg[QUO_W].side;
    end

    assign out_valid = out_v_reg;
    assign out_unit  = out_u_reg;
    assign out_side  = out_s_reg;

endmodule

/* rtl/core/look_at_view_matrix_core.sv */
// Look-at view matrix core: back, right and upward axes plus translations.
// Depends on lav_pkg and lav_norm.
//
// Usage:
//   Drive eye, target and up (signed Q16.16) and raise start for one cycle
//   per item. busy is always low, so an item is taken on every cycle that
//   start is high: one item per cycle sustained.
//   The nine rotation entries and three translations appear at the outputs,
//   valid for exactly one cycle while done is high.
//   Each of the two normalizers holds a 32-stage root pipeline and a
//   17-stage divider; eight more stages hold the eye - target difference,
//   cross products, rounding and dot sums.
//   A zero-length vector normalizes to the zero vector; translations
//   saturate to the signed 32-bit range.
//   Reset clears every valid bit: no result follows an item in flight.
//   The receiver cannot stall; results must be taken when done is high.
module look_at_view_matrix_core import lav_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               done,
    output logic signed [31:0] right_x,
    output logic signed [31:0] right_y,
    output logic signed [31:0] right_z,
    output logic signed [31:0] upward_x,
    output logic signed [31:0] upward_y,
    output logic signed [31:0] upward_z,
    output logic signed [31:0] back_x,
    output logic signed [31:0] back_y,
    output logic signed [31:0] back_z,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y,
    output logic signed [31:0] shift_z
);

    assign busy = 1'b0;

    // stage 0: eye - target, exact
    logic               in_v_reg;
    logic signed [32:0] d_reg [3];
    side_t              in_side_reg;

    always_ff @(posedge clk)
    begin
        d_reg[0]    <= 33'(eye_x) - 33'(target_x);
        d_reg[1]    <= 33'(eye_y) - 33'(target_y);
        d_reg[2]    <= 33'(eye_z) - 33'(target_z);
        in_side_reg <= {eye_x, eye_y, eye_z, up_x, up_y, up_z};
    end

    // back axis
    vec_comp_t n1_in [3];
    logic      n1_v;
    unit_t     zu [3];
    side_t     n1_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_in[i] = VEC_W'(d_reg[i]);
    end

    lav_norm u_norm_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_v_reg),
        .in_vec   (n1_in),
        .in_side  (in_side_reg),
        .out_valid(n1_v),
        .out_unit (zu),
        .out_side (n1_side)
    );

    // up cross back: products, then differences
    logic signed [31:0] up_a [3];
    logic signed [95:0] eye1;
    logic               cp_v_reg;
    logic signed [49:0] cp_reg [6];
    unit_t              cp_z_reg [3];
    logic [95:0]        cp_eye_reg;

    assign eye1    = n1_side[191:96];
    assign up_a[0] = n1_side[95:64];
    assign up_a[1] = n1_side[63:32];
    assign up_a[2] = n1_side[31:0];

    always_ff @(posedge clk)
    begin
        cp_reg[0]  <= up_a[1] * zu[2];
        cp_reg[1]  <= up_a[2] * zu[1];
        cp_reg[2]  <= up_a[2] * zu[0];
        cp_reg[3]  <= up_a[0] * zu[2];
        cp_reg[4]  <= up_a[0] * zu[1];
        cp_reg[5]  <= up_a[1] * zu[0];
        cp_z_reg   <= zu;
        cp_eye_reg <= eye1;
    end

    logic      cd_v_reg;
    vec_comp_t cd_reg [3];
    side_t     cd_side_reg;

    always_ff @(posedge clk)
    begin
        cd_reg[0]   <= cp_reg[0] - cp_reg[1];
        cd_reg[1]   <= cp_reg[2] - cp_reg[3];
        cd_reg[2]   <= cp_reg[4] - cp_reg[5];
        cd_side_reg <= {cp_eye_reg, cp_z_reg[0], cp_z_reg[1], cp_z_reg[2], 42'b0};
    end

    // right axis
    logic  n2_v;
    unit_t xu [3];
    side_t n2_side;

    lav_norm u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cd_v_reg),
        .in_vec   (cd_reg),
        .in_side  (cd_side_reg),
        .out_valid(n2_v),
        .out_unit (xu),
        .out_side (n2_side)
    );

    unit_t              z2 [3];
    logic signed [31:0] eye2 [3];

    assign eye2[0] = n2_side[191:160];
    assign eye2[1] = n2_side[159:128];
    assign eye2[2] = n2_side[127:96];
    assign z2[0]   = n2_side[95:78];
    assign z2[1]   = n2_side[77:60];
    assign z2[2]   = n2_side[59:42];

    // back cross right: products
    logic               yp_v_reg;
    logic signed [35:0] yp_reg [6];
    unit_t              yp_x_reg [3];
    unit_t              yp_z_reg [3];
    logic signed [31:0] yp_eye_reg [3];

    always_ff @(posedge clk)
    begin
        yp_reg[0]  <= z2[1] * xu[2];
        yp_reg[1]  <= z2[2] * xu[1];
        yp_reg[2]  <= z2[2] * xu[0];
        yp_reg[3]  <= z2[0] * xu[2];
        yp_reg[4]  <= z2[0] * xu[1];
        yp_reg[5]  <= z2[1] * xu[0];
        yp_x_reg   <= xu;
        yp_z_reg   <= z2;
        yp_eye_reg <= eye2;
    end

    // differences, round half up to Q16.16
    logic               yr_v_reg;
    logic signed [19:0] yr_reg [3];
    unit_t              yr_x_reg [3];
    unit_t              yr_z_reg [3];
    logic signed [31:0] yr_eye_reg [3];
    logic signed [36:0] ys [3];

    always_comb
    begin
        ys[0] = 37'(yp_reg[0]) - 37'(yp_reg[1]) + 37'sd32768;
        ys[1] = 37'(yp_reg[2]) - 37'(yp_reg[3]) + 37'sd32768;
        ys[2] = 37'(yp_reg[4]) - 37'(yp_reg[5]) + 37'sd32768;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            yr_reg[i] <= ys[i][35:16];
        yr_x_reg   <= yp_x_reg;
        yr_z_reg   <= yp_z_reg;
        yr_eye_reg <= yp_eye_reg;
    end

    // translation products
    logic               dp_v_reg;
    logic signed [53:0] dpx_reg [3];
    logic signed [53:0] dpy_reg [3];
    logic signed [53:0] dpz_reg [3];
    unit_t              dp_x_reg [3];
    logic signed [19:0] dp_y_reg [3];
    unit_t              dp_z_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dpx_reg[i] <= yr_x_reg[i] * yr_eye_reg[i];
            dpy_reg[i] <= yr_reg[i] * yr_eye_reg[i];
            dpz_reg[i] <= yr_z_reg[i] * yr_eye_reg[i];
        end
        dp_x_reg <= yr_x_reg;
        dp_y_reg <= yr_reg;
        dp_z_reg <= yr_z_reg;
    end

    // dot sums, exact in Q32
    logic               ds_v_reg;
    logic signed [53:0] ds_reg [3];
    unit_t              ds_x_reg [3];
    logic signed [19:0] ds_y_reg [3];
    unit_t              ds_z_reg [3];

    always_ff @(posedge clk)
    begin
        ds_reg[0] <= dpx_reg[0] + dpx_reg[1] + dpx_reg[2];
        ds_reg[1] <= dpy_reg[0] + dpy_reg[1] + dpy_reg[2];
        ds_reg[2] <= dpz_reg[0] + dpz_reg[1] + dpz_reg[2];
        ds_x_reg  <= dp_x_reg;
        ds_y_reg  <= dp_y_reg;
        ds_z_reg  <= dp_z_reg;
    end

    // round, negate, saturate; register the result
    logic signed [53:0] rt_sum [3];
    logic signed [38:0] rt_neg [3];
    logic signed [31:0] sh_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rt_sum[i] = ds_reg[i] + 54'sd32768;
            rt_neg[i] = -$signed(rt_sum[i][53:16]);
            if (rt_neg[i] > 39'sd2147483647)
                sh_next[i] = 32'sh7fffffff;
            else if (rt_neg[i] < -39'sd2147483648)
                sh_next[i] = 32'sh80000000;
            else
                sh_next[i] = rt_neg[i][31:0];
        end
    end

    logic               out_v_reg;
    logic signed [31:0] o_x_reg [3];
    logic signed [31:0] o_y_reg [3];
    logic signed [31:0] o_z_reg [3];
    logic signed [31:0] o_s_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_x_reg[i] <= 32'(ds_x_reg[i]);
            o_y_reg[i] <= 32'(ds_y_reg[i]);
            o_z_reg[i] <= 32'(ds_z_reg[i]);
        end
        o_s_reg <= sh_next;
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            cp_v_reg  <= 1'b0;
            cd_v_reg  <= 1'b0;
            yp_v_reg  <= 1'b0;
            yr_v_reg  <= 1'b0;
            dp_v_reg  <= 1'b0;
            ds_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= start;
            cp_v_reg  <= n1_v;
            cd_v_reg  <= cp_v_reg;
            yp_v_reg  <= n2_v;
            yr_v_reg  <= yp_v_reg;
            dp_v_reg  <= yr_v_reg;
            ds_v_reg  <= dp_v_reg;
            out_v_reg <= ds_v_reg;
        end
    end

    assign done     = out_v_reg;
    assign right_x  = o_x_reg[0];
    assign right_y  = o_x_reg[1];
    assign right_z  = o_x_reg[2];
    assign upward_x = o_y_reg[0];
    assign upward_y = o_y_reg[1];
    assign upward_z = o_y_reg[2];
    assign back_x   = o_z_reg[0];
    assign back_y   = o_z_reg[1];
    assign back_z   = o_z_reg[2];
    assign shift_x  = o_s_reg[0];
    assign shift_y  = o_s_reg[1];
    assign shift_z  = o_s_reg[2];

    // unit components never exceed one; checked on right_x and back_z
    a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (right_x <= 32'sd65536 && right_x >= -32'sd65536 &&
                  back_z <= 32'sd65536 && back_z >= -32'sd65536))
        else $error("unit component out of range");

    // zero back axis gives a zero right axis
    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        (done && back_x == 0 && back_y == 0 && back_z == 0) |->
        (right_x == 0 && right_y == 0 && right_z == 0))
        else $error("right axis not zero for zero back axis");

    // zero right axis gives a zero upward axis
    a_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
        (done && right_x == 0 && right_y == 0 && right_z == 0) |->
        (upward_x == 0 && upward_y == 0 && upward_z == 0))
        else $error("upward axis not zero for zero right axis");

endmodule
